>>> sv/pli_pkg.sv
// Shared types and codes for the palette lookup interpolator.
`default_nettype none

package pli_pkg;

    // Request action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    localparam int COLOR_W  = 32;
    localparam int PIXEL_W  = 16;
    localparam int ENTRY_W  = 9;
    localparam int WEIGHT_W = 8;
    localparam int LANES    = 4;
    localparam int LANE_W   = 8;

    // Classified command passed from front to back through the queue.
    // index: write address for palette writes, masked palette index for pixels.
    typedef struct packed {
        logic                action;
        logic [ENTRY_W-1:0]  index;
        logic [WEIGHT_W-1:0] weight;
        logic [COLOR_W-1:0]  color;
        logic                eol;
    } t_cmd;

endpackage

`default_nettype wire

>>> sv/pli_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface pli_req_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [pli_pkg::PIXEL_W-1:0]         pixel_value;
    logic [pli_pkg::ENTRY_W-1:0]         entry_index;
    logic [pli_pkg::COLOR_W-1:0]         entry_color;
    logic                                end_of_line;

    modport source (
        output valid, action, pixel_value, entry_index, entry_color, end_of_line,
        input  ready
    );
    modport sink (
        input  valid, action, pixel_value, entry_index, entry_color, end_of_line,
        output ready
    );
endinterface

interface pli_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pli_pkg::COLOR_W-1:0]   color;
    logic                          line_done;

    modport source (
        output valid, color, line_done,
        input  ready
    );
    modport sink (
        input  valid, color, line_done,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/pli_front.sv
// Front end: accepts requests, classifies them and drops out-of-range writes.
`default_nettype none

module pli_front #(
    parameter int INDEX_BITS = 8
) (
    input  wire logic           i_req_valid,
    input  wire logic           i_action,
    input  wire logic [15:0]    i_pixel_value,
    input  wire logic [8:0]     i_entry_index,
    input  wire logic [31:0]    i_entry_color,
    input  wire logic           i_end_of_line,
    input  wire logic           i_q_full,
    output pli_pkg::t_cmd       o_cmd,
    output logic                o_push,
    output logic                o_ready
);

    localparam int         PAL_DEPTH = (1 << INDEX_BITS) + 1;
    localparam logic [7:0] IDX_MASK  = 8'((1 << INDEX_BITS) - 1);

    logic accept;
    logic in_range;

    assign o_ready  = !i_q_full;
    assign accept   = i_req_valid && !i_q_full;
    assign in_range = 32'(i_entry_index) < 32'(PAL_DEPTH);

    always_comb begin
        o_cmd.action = i_action;
        o_cmd.weight = i_pixel_value[7:0];
        o_cmd.color  = i_entry_color;
        o_cmd.eol    = i_end_of_line;
        if (i_action == pli_pkg::ACT_PIXEL) begin
            o_cmd.index = {1'b0, i_pixel_value[15:8] & IDX_MASK};
        end else begin
            o_cmd.index = i_entry_index;
        end
    end

    // writes past the last entry are accepted and discarded
    assign o_push = accept && ((i_action == pli_pkg::ACT_PIXEL) || in_range);

endmodule

`default_nettype wire

>>> sv/pli_queue.sv
// Two-entry command queue between front and back.
`default_nettype none

module pli_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  pli_pkg::t_cmd       i_cmd,
    input  wire logic           i_pop,
    output pli_pkg::t_cmd       o_cmd,
    output logic                o_valid,
    output logic                o_full
);

    pli_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/pli_back.sv
// Back end: palette memory, neighbor read and per-byte linear blend.
`default_nettype none

module pli_back #(
    parameter int INDEX_BITS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  pli_pkg::t_cmd       i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_pop,
    input  wire logic           i_rsp_ready,
    output logic                o_rsp_valid,
    output logic [31:0]         o_color,
    output logic                o_line_done
);

    localparam int PAL_DEPTH = (1 << INDEX_BITS) + 1;
    localparam int ADDR_W    = $clog2(PAL_DEPTH);

    logic [31:0]       r_palette [PAL_DEPTH];

    logic              adv;
    logic              is_pixel;
    logic [ADDR_W-1:0] addr;

    // read stage
    logic              r_a_valid;
    logic [31:0]       r_lo;
    logic [31:0]       r_hi;
    logic [7:0]        r_f;
    logic              r_a_eol;

    // blend / output stage
    logic              r_b_valid;
    logic [31:0]       r_color;
    logic              r_b_eol;
    logic [31:0]       n_color;

    assign adv      = !r_b_valid || i_rsp_ready;
    assign o_pop    = adv && i_cmd_valid;
    assign is_pixel = (i_cmd.action == pli_pkg::ACT_PIXEL);
    assign addr     = ADDR_W'(i_cmd.index);

    // writes pop in order, so a later pixel always sees them
    always_ff @(posedge i_clk) begin
        if (o_pop && !is_pixel) begin
            r_palette[addr] <= i_cmd.color;
        end
        if (adv) begin
            r_lo    <= r_palette[addr];
            r_hi    <= r_palette[addr + ADDR_W'(1)];
            r_f     <= i_cmd.weight;
            r_a_eol <= i_cmd.eol;
        end
    end

    always_comb begin
        logic [8:0]  g;
        logic [16:0] acc;
        n_color = '0;
        g       = 9'd256 - {1'b0, r_f};
        for (int l = 0; l < pli_pkg::LANES; l++) begin
            acc = 17'(r_lo[l*8 +: 8]) * 17'(g) + 17'(r_hi[l*8 +: 8]) * 17'(r_f);
            n_color[l*8 +: 8] = acc[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= o_pop && is_pixel;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_color <= n_color;
            r_b_eol <= r_a_eol;
        end
    end

    assign o_rsp_valid = r_b_valid;
    assign o_color     = r_color;
    assign o_line_done = r_b_eol;

endmodule

`default_nettype wire

>>> sv/palette_lookup_interpolate_top.sv
// Top level of the palette lookup interpolator.
//
// Requests arrive on i_req (valid/ready). A request with action = write
// stores entry_color at palette entry entry_index; writes past the last
// entry are accepted and dropped. A request with action = pixel uses
// pixel_value[15:8] (masked to INDEX_BITS) as palette index i and
// pixel_value[7:0] as weight f, and returns on o_rsp one color whose bytes
// are (entry[i]*(256-f) + entry[i+1]*f) >> 8, with line_done = end_of_line.
// Writes produce no result.
//
// Throughput: one request per clock while o_rsp is ready, set by the
// two-read-port palette memory and the single blend stage. A pixel goes
// through the queue, the read stage and the blend/output stage to o_rsp.
// The front classifies requests into a two-entry queue; the back pops,
// reads entries i and i+1 and blends. When o_rsp stalls the back holds
// and the queue takes up to two more requests before i_req.ready drops.
// Synchronous reset (i_rst_n low) empties the queue and pipeline; palette
// contents are undefined until written.
`default_nettype none

module palette_lookup_interpolate_top #(
    parameter int INDEX_BITS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pli_req_if.sink     i_req,
    pli_rsp_if.source   o_rsp
);

    pli_pkg::t_cmd front_cmd;
    pli_pkg::t_cmd queue_cmd;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;
    logic          front_ready;

    pli_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_req_valid   (i_req.valid),
        .i_action      (i_req.action),
        .i_pixel_value (i_req.pixel_value),
        .i_entry_index (i_req.entry_index),
        .i_entry_color (i_req.entry_color),
        .i_end_of_line (i_req.end_of_line),
        .i_q_full      (q_full),
        .o_cmd         (front_cmd),
        .o_push        (push),
        .o_ready       (front_ready)
    );

    assign i_req.ready = front_ready;

    // decouples request acceptance from back-end stalls
    pli_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    pli_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (q_valid),
        .o_pop       (pop),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_color     (o_rsp.color),
        .o_line_done (o_rsp.line_done)
    );

endmodule

`default_nettype wire

>>> test/palette_lookup_interpolate_top_tb.sv
// Self-checking testbench for the palette lookup interpolator top level.
`default_nettype none

module palette_lookup_interpolate_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 10;
    localparam int INDEX_BITS     = 8;
    localparam int PAL_DEPTH      = (1 << INDEX_BITS) + 1;
    localparam int IDX_MASK       = (1 << INDEX_BITS) - 1;
    localparam int PHASE_ITEMS    = 450;
    // Long receiver hold-off, well past the depth of the queue and pipeline
    localparam int PRESSURE_HOLD  = 300;
    // Quiet cycles tolerated before the run is declared hung; covers the
    // pressure hold plus the longest random stall with a wide margin.
    localparam int WATCHDOG_LIMIT = 5000;
    // Cycles waited after the last expected result before deciding.
    localparam int DRAIN_CYCLES   = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pli_req_if req_if ();
    pli_rsp_if rsp_if ();

    palette_lookup_interpolate_top #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // One request as the sender sees it
    typedef struct {
        logic        action;
        logic [15:0] pixel_value;
        logic [8:0]  entry_index;
        logic [31:0] entry_color;
        logic        end_of_line;
    } t_req_item;

    typedef struct {
        logic [31:0] color;
        logic        line_done;
    } t_color_result;

    // Shadow palette plus the queue of colors still owed by the block.
    class palette_blend_scoreboard;
        logic [31:0]   palette [PAL_DEPTH];
        t_color_result expected_colors [$];
        int            failures;

        function new();
            failures = 0;
            foreach (palette[k]) palette[k] = '0;
        endfunction

        // Per byte lane: (lo * (256 - f) + hi * f) >> 8
        function logic [31:0] blend_lanes(logic [31:0] lo, logic [31:0] hi, int f);
            logic [31:0] res;
            int acc;
            res = '0;
            for (int lane = 0; lane < pli_pkg::LANES; lane++) begin
                acc = int'(lo[lane*pli_pkg::LANE_W +: pli_pkg::LANE_W]) * (256 - f)
                    + int'(hi[lane*pli_pkg::LANE_W +: pli_pkg::LANE_W]) * f;
                res[lane*pli_pkg::LANE_W +: pli_pkg::LANE_W] = acc[15:8];
            end
            return res;
        endfunction

        function void note_request(t_req_item r);
            t_color_result exp_res;
            int idx;
            if (r.action == pli_pkg::ACT_WRITE) begin
                // writes past the last entry are dropped
                if (int'(r.entry_index) < PAL_DEPTH)
                    palette[r.entry_index] = r.entry_color;
            end else begin
                idx = int'(r.pixel_value[15:8]) & IDX_MASK;
                exp_res.color = blend_lanes(palette[idx], palette[idx + 1],
                                            int'(r.pixel_value[7:0]));
                exp_res.line_done = r.end_of_line;
                expected_colors.push_back(exp_res);
            end
        endfunction

        function void check_result(logic [31:0] color, logic line_done);
            t_color_result exp_res;
            if (expected_colors.size() == 0) begin
                $error("unexpected result: color %h line_done %b", color, line_done);
                failures++;
                return;
            end
            exp_res = expected_colors.pop_front();
            if (color !== exp_res.color) begin
                $error("color: expected %h actual %h", exp_res.color, color);
                failures++;
            end
            if (line_done !== exp_res.line_done) begin
                $error("line_done: expected %b actual %b", exp_res.line_done, line_done);
                failures++;
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    palette_blend_scoreboard sb = new();

    // Entries written so far, as the stimulus sees them. Pixels are only
    // generated on pairs i, i+1 that are both written.
    bit gen_written [PAL_DEPTH];

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;

    // Pressure handshake between the main flow and the receiver process
    int pressure_requests = 0;
    int pressure_served   = 0;
    int hold_left         = 0;

    initial rsp_if.ready = 1'b0;

    // Receiver: random stalls, plus a long hold-off when asked for.
    always @(posedge i_clk) begin
        if (pressure_served != pressure_requests) begin
            pressure_served <= pressure_requests;
            hold_left       <= PRESSURE_HOLD;
            rsp_if.ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.color, rsp_if.line_done);
    end

    // Watchdog: any cycle without a handshake on either channel counts.
    initial begin
        int quiet;
        quiet = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit pair_readable(int idx);
        return gen_written[idx] && gen_written[idx + 1];
    endfunction

    function automatic t_req_item write_req(logic [8:0] idx, logic [31:0] color);
        t_req_item r;
        r.action      = pli_pkg::ACT_WRITE;
        r.pixel_value = 16'($urandom);
        r.entry_index = idx;
        r.entry_color = color;
        r.end_of_line = 1'($urandom);
        if (int'(idx) < PAL_DEPTH)
            gen_written[idx] = 1'b1;
        return r;
    endfunction

    function automatic t_req_item pixel_req(logic [15:0] pix, logic eol);
        t_req_item r;
        r.action      = pli_pkg::ACT_PIXEL;
        r.pixel_value = pix;
        r.entry_index = 9'($urandom);
        r.entry_color = $urandom;
        r.end_of_line = eol;
        return r;
    endfunction

    // Random request: mostly pixels on written pairs, some palette
    // rewrites, a few writes past the end of the palette.
    function automatic t_req_item random_req();
        logic [15:0] pix;
        int start;
        int idx;
        int sel;
        sel = $urandom_range(99);
        if (sel < 4)
            return write_req(9'($urandom_range(511, PAL_DEPTH)), $urandom);
        if (sel < 30)
            return write_req(9'($urandom_range(PAL_DEPTH - 1)), $urandom);
        pix = 16'($urandom);
        // weight extremes now and then
        sel = $urandom_range(9);
        if (sel == 0) pix[7:0] = 8'h00;
        else if (sel == 1) pix[7:0] = 8'hFF;
        idx = int'(pix[15:8]) & IDX_MASK;
        if (!pair_readable(idx)) begin
            start = $urandom_range(IDX_MASK);
            for (int k = 0; k <= IDX_MASK; k++) begin
                idx = (start + k) & IDX_MASK;
                if (pair_readable(idx)) break;
            end
            pix[15:8] = 8'(idx);
        end
        return pixel_req(pix, ($urandom_range(3) == 0));
    endfunction

    // Offer one request, with random idle cycles ahead of it, and wait
    // for the handshake. valid is left high for a back-to-back follower.
    task automatic send_request(input t_req_item r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.action      <= r.action;
        req_if.pixel_value <= r.pixel_value;
        req_if.entry_index <= r.entry_index;
        req_if.entry_color <= r.entry_color;
        req_if.end_of_line <= r.end_of_line;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(r);
    endtask

    initial begin
        t_req_item directed [$];

        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.action      <= pli_pkg::ACT_WRITE;
        req_if.pixel_value <= '0;
        req_if.entry_index <= '0;
        req_if.entry_color <= '0;
        req_if.end_of_line <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: color extremes at both ends of the palette, the last
        // entry (only reachable as i+1), writes past the end that must be
        // dropped, zero and full weight, and overwriting entries.
        directed.push_back(write_req(9'd0,   32'h0000_0000));
        directed.push_back(write_req(9'd1,   32'hFFFF_FFFF));
        directed.push_back(write_req(9'd255, 32'h80FF_017F));
        directed.push_back(write_req(9'd256, 32'hFFFF_FFFF));
        directed.push_back(write_req(9'd257, 32'h0000_0000));
        directed.push_back(write_req(9'd511, 32'h0000_0000));
        directed.push_back(pixel_req(16'h0000, 1'b0));
        directed.push_back(pixel_req(16'h00FF, 1'b1));
        directed.push_back(pixel_req(16'h0080, 1'b0));
        directed.push_back(pixel_req(16'hFFFF, 1'b1));
        directed.push_back(pixel_req(16'hFF00, 1'b0));
        directed.push_back(pixel_req(16'hFF80, 1'b0));
        directed.push_back(write_req(9'd0,   32'hFFFF_FFFF));
        directed.push_back(write_req(9'd1,   32'h0000_0000));
        directed.push_back(pixel_req(16'h0001, 1'b0));
        directed.push_back(pixel_req(16'h00FF, 1'b1));
        directed.push_back(write_req(9'd254, 32'h00FF_00FF));
        directed.push_back(pixel_req(16'hFE40, 1'b1));
        directed.push_back(pixel_req(16'hFEC0, 1'b0));
        foreach (directed[k]) send_request(directed[k]);

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 62; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 62; end
                default: begin send_idle_pct = 35; rsp_stall_pct = 35; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // back up the block while requests keep coming
                if (phase == 0 && n == 200)
                    pressure_requests <= pressure_requests + 1;
                send_request(random_req());
            end
        end
        req_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
